// ===== rtl/multichannel_led_fader_assert.svh =====
// Assertion macros used by the fader top level.
`ifndef MULTICHANNEL_LED_FADER_ASSERT_SVH
`define MULTICHANNEL_LED_FADER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MLF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define MLF_ASSERT_IMPLY(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

`endif

// ===== rtl/mlf_pkg.sv =====
// Shared constants and types of the multichannel LED fader.
package mlf_pkg;

	localparam int CHANNELS = 32;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int KIND_W = 2;
	localparam int CH_W = 6;
	localparam int LVL_W = 8;
	localparam int GREY_W = 12;
	localparam int GREY_SHIFT = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [LVL_W-1:0] LEVEL_MAX = 8'hFF;
	localparam logic [LVL_W-1:0] STEP_RESET = 8'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_TARGET = 2'd1,
		KIND_LEVEL  = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_STEP   = 1'b0,
		CFG_FADE_ENABLE = 1'b1
	} cfg_idx_t;

	// Result of one pass through the ramp unit.
	typedef struct packed {
		logic             changed;
		logic [LVL_W-1:0] level;
	} ramp_t;

	// Result handed to the output register.
	typedef struct packed {
		logic              load;
		logic [CH_W-1:0]   channel;
		logic [GREY_W-1:0] greyscale;
		logic              last;
	} out_req_t;

endpackage

// ===== rtl/mlf_ramp_unit.sv =====
// Shared saturating ramp unit: one channel's next level per use.
module mlf_ramp_unit (
	input  logic [mlf_pkg::LVL_W-1:0] level,
	input  logic                      target_on,
	input  logic [mlf_pkg::LVL_W-1:0] step,
	output mlf_pkg::ramp_t            result
);
	import mlf_pkg::*;

	logic [LVL_W:0] sum;

	assign sum = {1'b0, level} + {1'b0, step};

	always_comb begin
		result = '0;
		if (target_on) begin
			result.changed = (level != LEVEL_MAX);
			result.level = sum[LVL_W] ? LEVEL_MAX : sum[LVL_W-1:0];
		end else begin
			result.changed = (level != '0);
			result.level = (level > step) ? (level - step) : '0;
		end
	end

endmodule

// ===== rtl/mlf_out_reg.sv =====
// Output register of the result stream.
module mlf_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mlf_pkg::out_req_t           req,
	output logic                        can_load,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,
	output logic                        m_tlast
);
	import mlf_pkg::*;

	logic              valid_q;
	logic [CH_W-1:0]   ch_q;
	logic [GREY_W-1:0] grey_q;
	logic              last_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= req.load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && req.load) begin
			ch_q <= req.channel;
			grey_q <= req.greyscale;
			last_q <= req.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {{(24 - GREY_W - CH_W){1'b0}}, grey_q, ch_q};
	assign m_tlast = last_q;

endmodule

// ===== rtl/multichannel_led_fader.sv =====
// Top level of the multichannel LED fader: channel state, sequencer, ports.
// A target transaction leaves the sequencer idle; a level transaction passes through the
// flush state, which loads its result into the output register. A tick sweeps the channels,
// one channel per cycle through the shared ramp unit while the result stream does not stall,
// then flushes the last changed channel, if any; the block takes no input while a tick is running.
// Reset (arst_n low, asynchronous): targets off, levels 255, fade_step 16, fading on.
module multichannel_led_fader (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,  // channel[5:0], value[13:6]
	input  logic [mlf_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,  // out_channel[5:0], greyscale[17:6]
	output logic                               m_tlast,
	// Configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mlf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mlf_pkg::LVL_W-1:0]          cfg_data
);
	import mlf_pkg::*;

	`include "multichannel_led_fader_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic              pend_valid_q;
	logic [CH_W-1:0]   pend_ch_q;
	logic [LVL_W-1:0]  pend_lvl_q;
	logic [LVL_W-1:0]  fade_step_q;
	logic              fade_enable_q;
	logic              target_q [CHANNELS];
	logic [LVL_W-1:0]  level_q  [CHANNELS];

	kind_t             in_kind;
	logic [CH_W-1:0]   in_ch;
	logic [LVL_W-1:0]  in_val;
	logic              in_accept;
	logic              in_ch_ok;
	logic [IDX_W-1:0]  in_idx;

	ramp_t             ramp;
	logic              need_push;
	logic              scan_adv;
	logic              scan_end;
	logic              out_can_load;
	out_req_t          out_req;

	// Unpack the input transaction
	assign in_kind = kind_t'(s_tuser);
	assign in_ch = s_tdata[CH_W-1:0];
	assign in_val = s_tdata[CH_W +: LVL_W];
	assign in_idx = in_ch[IDX_W-1:0];
	assign in_ch_ok = ({1'b0, in_ch} < (CH_W + 1)'(CHANNELS));

	assign s_tready = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// One channel per cycle through the shared ramp unit, unless the sweep stalls
	mlf_ramp_unit u_ramp (
		.level     (level_q[idx_q]),
		.target_on (target_q[idx_q]),
		.step      (fade_step_q),
		.result    (ramp)
	);

	// A changed channel must first retire the pending result; stall when the
	// output register cannot take it.
	assign need_push = ramp.changed && pend_valid_q;
	assign scan_adv = !need_push || out_can_load;
	assign scan_end = (idx_q == IDX_W'(CHANNELS - 1));

	always_comb begin
		out_req = '0;
		out_req.channel = pend_ch_q;
		out_req.greyscale = GREY_W'(pend_lvl_q) << GREY_SHIFT;
		out_req.last = (state_q == ST_FLUSH);
		case (state_q)
			ST_SCAN:  out_req.load = need_push && scan_adv;
			ST_FLUSH: out_req.load = 1'b1;
			default:  out_req.load = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (in_kind == KIND_LEVEL && in_ch_ok) begin
						state_d = ST_FLUSH;
					end else if (in_kind == KIND_TICK && fade_enable_q) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_adv && scan_end) begin
					state_d = (pend_valid_q || ramp.changed) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_accept && in_kind == KIND_LEVEL && in_ch_ok) begin
						pend_valid_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_adv) begin
						idx_q <= idx_q + 1'b1;
						if (ramp.changed) begin
							pend_valid_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_can_load) begin
						pend_valid_q <= 1'b0;
					end
				end
				default: pend_valid_q <= 1'b0;
			endcase
		end
	end

	// Hold the result that waits to learn whether it closes the run
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_accept) begin
			pend_ch_q <= in_ch;
			pend_lvl_q <= in_val;
		end else if (state_q == ST_SCAN && scan_adv && ramp.changed) begin
			pend_ch_q <= CH_W'(idx_q);
			pend_lvl_q <= ramp.level;
		end
	end

	// Channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				target_q[i] <= 1'b0;
				level_q[i] <= LEVEL_MAX;
			end
		end else if (state_q == ST_IDLE) begin
			if (in_accept && in_ch_ok) begin
				if (in_kind == KIND_TARGET) begin
					target_q[in_idx] <= (in_val != '0);
				end else if (in_kind == KIND_LEVEL) begin
					level_q[in_idx] <= in_val;
				end
			end
		end else if (state_q == ST_SCAN && scan_adv && ramp.changed) begin
			level_q[idx_q] <= ramp.level;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q <= STEP_RESET;
			fade_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FADE_STEP:   fade_step_q <= cfg_data;
				CFG_FADE_ENABLE: fade_enable_q <= cfg_data[0];
				default:         fade_step_q <= fade_step_q;
			endcase
		end
	end

	mlf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (out_req),
		.can_load (out_can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Nothing may wait in the pending slot once the sequencer is idle.
	`MLF_ASSERT_IMPLY(a_idle_no_pending, state_q == ST_IDLE, !pend_valid_q, "idle with pending")
	// The flush state always has a result to close the run.
	`MLF_ASSERT(a_flush_has_pending, state_q != ST_FLUSH || pend_valid_q, "empty flush")
	// The sweep stalls only to retire a pending result into a full output register.
	`MLF_ASSERT_IMPLY(a_stall_cause, !scan_adv, pend_valid_q && m_tvalid && !m_tready, "bad stall")

endmodule

// ===== dv/multichannel_led_fader_tb.sv =====
// Self-checking testbench of the multichannel LED fader: directed and random streams.
module multichannel_led_fader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlf_pkg::*;

	// Run limit: several times the slowest correct run (ticks at full fan-out into
	// a receiver that is ready one cycle in eight, plus the long hold-off).
	localparam int LIMIT_NS = 3_200_000;
	// Quiet time after the last result: one full tick sweep and some margin.
	localparam int SETTLE_CYCLES = CHANNELS + 8;
	localparam int RANDOM_PER_MODE = 115;

	// One greyscale update as seen on the result stream.
	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [GREY_W-1:0] greyscale;
		logic              last;
	} grey_upd_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;   // channel[5:0], value[13:6]
	logic [KIND_W-1:0] s_tuser;   // kind[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [23:0]       m_tdata;   // out_channel[5:0], greyscale[17:6]
	logic              m_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LVL_W-1:0]  cfg_data;

	// Shadow copy of the channel state and registers.
	bit                fader_target_on [CHANNELS];
	logic [LVL_W-1:0]  fader_level [CHANNELS];
	logic [LVL_W-1:0]  fade_step_q;
	logic              fade_enable_q;

	grey_upd_t         grey_expected [$];
	int                fail_count;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                hold_cycles;

	multichannel_led_fader uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#LIMIT_NS;
		$display("FAIL");
		$finish;
	end

	// Apply one accepted item to the shadow state and queue the updates it causes.
	// Return 1 when the item does something, 0 when the block ignores it.
	function automatic bit predict_item(kind_t k, logic [CH_W-1:0] ch, logic [LVL_W-1:0] val);
		int lv;
		int n;
		grey_upd_t u;
		n = 0;
		case (k)
			KIND_TARGET: begin
				if (int'(ch) >= CHANNELS)
					return 1'b0;
				fader_target_on[ch[IDX_W-1:0]] = (val != '0);
				return 1'b1;
			end
			KIND_LEVEL: begin
				if (int'(ch) >= CHANNELS)
					return 1'b0;
				fader_level[ch[IDX_W-1:0]] = val;
				u.channel = ch;
				u.greyscale = {val, 4'h0};
				u.last = 1'b1;
				grey_expected.push_back(u);
				return 1'b1;
			end
			KIND_TICK: begin
				if (!fade_enable_q)
					return 1'b0;
				// Sweep channels in ascending order; skip those already at their bound.
				for (int i = 0; i < CHANNELS; i++) begin
					lv = int'(fader_level[i]);
					if (fader_target_on[i]) begin
						if (lv >= 255)
							continue;
						lv = lv + int'(fade_step_q);
						if (lv > 255)
							lv = 255;
					end else begin
						if (lv == 0)
							continue;
						lv = (lv > int'(fade_step_q)) ? lv - int'(fade_step_q) : 0;
					end
					fader_level[i] = lv[LVL_W-1:0];
					u.channel = i[CH_W-1:0];
					u.greyscale = {lv[LVL_W-1:0], 4'h0};
					u.last = 1'b0;
					grey_expected.push_back(u);
					n++;
				end
				// Mark the final update of the sweep.
				if (n > 0)
					grey_expected[grey_expected.size()-1].last = 1'b1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Offer one item, idling first at the current rate; predict on acceptance.
	// Valid stays high afterwards so back-to-back items need no gap.
	task automatic send_item(kind_t k, logic [CH_W-1:0] ch, logic [LVL_W-1:0] val,
			output bit effective);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = k;
		s_tdata = {2'b00, val, ch};
		do
			@(posedge clk);
		while (!s_tready);
		effective = predict_item(k, ch, val);
	endtask

	// Drop the input and hold until every queued update has come out, then let the
	// block finish any sweep that emits nothing.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (grey_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(cfg_idx_t idx, logic [LVL_W-1:0] data);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_FADE_STEP:   fade_step_q = data;
			CFG_FADE_ENABLE: fade_enable_q = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: honor a pending hold-off, otherwise be ready at the current rate.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transaction with the oldest queued update.
	always @(posedge clk) begin
		grey_upd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (grey_expected.size() == 0) begin
				$display("%0t: unexpected result ch %0d grey %0d last %0d", $realtime,
					m_tdata[5:0], m_tdata[17:6], m_tlast);
				fail_count++;
			end else begin
				want = grey_expected.pop_front();
				if (m_tdata[5:0] !== want.channel || m_tdata[17:6] !== want.greyscale
						|| m_tlast !== want.last) begin
					$display("%0t: result mismatch, expected ch %0d grey %0d last %0d,",
						$realtime, want.channel, want.greyscale, want.last);
					$display("%0t:   actual ch %0d grey %0d last %0d", $realtime,
						m_tdata[5:0], m_tdata[17:6], m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Tick straight out of reset: every channel ramps down from full scale by 16.
	// The channel and value fields of a tick carry junk that must be ignored.
	task automatic test_reset_sweep();
		bit eff;
		send_item(KIND_TICK, 6'h3F, 8'hFF, eff);
		wait_drained();
	endtask

	// Level loads at both extremes, targets with zero and arbitrary nonzero values.
	task automatic test_level_and_target();
		bit eff;
		send_item(KIND_LEVEL, 6'd0, 8'h00, eff);
		send_item(KIND_LEVEL, 6'd31, 8'hFF, eff);
		send_item(KIND_LEVEL, 6'd10, 8'hAA, eff);
		send_item(KIND_TARGET, 6'd0, 8'h01, eff);
		send_item(KIND_TARGET, 6'd31, 8'h00, eff);
		send_item(KIND_TARGET, 6'd10, 8'h80, eff);
		send_item(KIND_TARGET, 6'd11, 8'h55, eff);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		wait_drained();
	endtask

	// Unused kind and out-of-range channels must leave state untouched.
	task automatic test_ignored_items();
		bit eff;
		send_item(KIND_UNUSED, 6'd3, 8'hFF, eff);
		send_item(KIND_LEVEL, 6'd32, 8'h12, eff);
		send_item(KIND_LEVEL, 6'd63, 8'hFF, eff);
		send_item(KIND_TARGET, 6'd40, 8'h01, eff);
		send_item(KIND_TICK, 6'h2A, 8'h3C, eff);
		wait_drained();
	endtask

	// Largest step saturates in one sweep, after which a sweep has nothing to do;
	// a zero step re-emits unchanged levels; then the smallest nonzero step.
	task automatic test_step_extremes();
		bit eff;
		write_reg(CFG_FADE_STEP, 8'hFF);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		write_reg(CFG_FADE_STEP, 8'h00);
		send_item(KIND_LEVEL, 6'd5, 8'd100, eff);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		write_reg(CFG_FADE_STEP, 8'h01);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		wait_drained();
	endtask

	// With fading off a tick does nothing; upper data bits of the enable are don't-care.
	task automatic test_fade_disable();
		bit eff;
		write_reg(CFG_FADE_ENABLE, 8'hFE);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		write_reg(CFG_FADE_ENABLE, 8'h01);
		write_reg(CFG_FADE_STEP, STEP_RESET);
	endtask

	// Hold the receiver off for a long stretch while items keep coming, so the
	// block fills up and stalls its input; then pause until everything drains.
	task automatic test_backpressure();
		bit eff;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 8; i++)
			send_item(KIND_TARGET, CH_W'(i * 4), (i % 2) ? 8'h00 : 8'h01, eff);
		@(negedge clk);
		s_tvalid = 1'b0;
		hold_cycles = 300;
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		send_item(KIND_LEVEL, 6'd7, 8'h40, eff);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		send_item(KIND_LEVEL, 6'd8, 8'hC0, eff);
		send_item(KIND_TICK, 6'd0, 8'h00, eff);
		wait_drained();
	endtask

	// Mostly well-formed traffic (targets, levels, ticks) with some noise, through
	// three idling regimes and periodic register changes.
	task automatic test_random_traffic();
		bit eff;
		int done;
		int since_cfg;
		int r;
		kind_t k;
		logic [CH_W-1:0] ch;
		logic [LVL_W-1:0] val;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 25; recv_idle_pct = 88; end
				1: begin send_idle_pct = 88; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			done = 0;
			since_cfg = 0;
			while (done < RANDOM_PER_MODE) begin
				r = $urandom_range(99);
				ch = CH_W'($urandom_range(CHANNELS-1));
				val = LVL_W'($urandom_range(255));
				if (r < 30) begin
					k = KIND_TICK;
					ch = CH_W'($urandom_range(63));
				end else if (r < 60) begin
					k = KIND_TARGET;
					if ($urandom_range(1))
						val = '0;
				end else if (r < 85) begin
					k = KIND_LEVEL;
					if ($urandom_range(7) == 0)
						val = $urandom_range(1) ? 8'hFF : 8'h00;
				end else if (r < 92) begin
					k = KIND_UNUSED;
					ch = CH_W'($urandom_range(63));
				end else begin
					k = $urandom_range(1) ? KIND_TARGET : KIND_LEVEL;
					ch = CH_W'($urandom_range(63, CHANNELS));
				end
				send_item(k, ch, val, eff);
				if (eff)
					done++;
				since_cfg++;
				// Change the registers now and then, extremes included.
				if (since_cfg >= 50) begin
					since_cfg = 0;
					r = $urandom_range(9);
					if (r == 0)
						write_reg(CFG_FADE_STEP, 8'h00);
					else if (r < 3)
						write_reg(CFG_FADE_STEP, 8'h01);
					else if (r < 5)
						write_reg(CFG_FADE_STEP, 8'hFF);
					else
						write_reg(CFG_FADE_STEP, LVL_W'($urandom_range(255)));
					write_reg(CFG_FADE_ENABLE,
						{7'($urandom_range(127)), ($urandom_range(5) != 0)});
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_TICK;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FADE_STEP;
		cfg_data = '0;
		fail_count = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Reset state: targets off, levels at full scale, default step, fading on.
		for (int i = 0; i < CHANNELS; i++) begin
			fader_target_on[i] = 1'b0;
			fader_level[i] = LEVEL_MAX;
		end
		fade_step_q = STEP_RESET;
		fade_enable_q = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_reset_sweep();
		test_level_and_target();
		test_ignored_items();
		test_step_extremes();
		test_fade_disable();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
